>>> hw/rtl/bec_pkg.sv
// Shared types and constants for the blink event counter.
`timescale 1ns / 1ps
`default_nettype none

package bec_pkg;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Field widths fixed by the sample and result formats.
   localparam int SAMPLE_W   = 16;
   localparam int TIMEOUT_W  = 16;
   localparam int TALLY_W    = 16;
   localparam int INTERVAL_W = 32;

   // Register reset values.
   localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = 16'sd256;
   localparam logic [TIMEOUT_W-1:0]       TIMEOUT_RESET   = 16'd60;

   // Saturation limits.
   localparam logic [TALLY_W-1:0]    TALLY_MAX    = 16'hFFFF;
   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 32'hFFFF_FFFF;

   // Register index, taken from the word address.
   typedef enum logic {
      REG_THRESHOLD       = 1'b0,
      REG_TIMEOUT_SAMPLES = 1'b1
   } csr_index_type;

   // One registered sample handed to the blink tracker.
   typedef struct packed {
      logic fire;
      logic now_open;
   } step_type;

endpackage

`default_nettype wire

>>> hw/rtl/blink_event_counter_core.sv
// Top level of the blink event counter: handshakes, registers and sample stage.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  req_eye_opening
//   rsp      out        rsp_valid/rsp_stall  rsp_blink_seen, rsp_blink_total,
//                                            rsp_mean_interval
//   csr      in/out     APB-style, pready=1  threshold @0, timeout_samples @4
//
// From transfer in to result out, a sample passes the input stage (threshold
// compare) and then the tracker update that loads the result.
// One sample is accepted per cycle while results are taken.
// Reset is synchronous and active high; it returns registers and state to
// their defaults and empties both stages.
// A stalled result holds; the input stage still takes one more sample.
`timescale 1ns / 1ps
`default_nettype none

module blink_event_counter_core #(
   parameter int INDEX_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [bec_pkg::SAMPLE_W-1:0] req_eye_opening,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_blink_seen,
   output logic [bec_pkg::TALLY_W-1:0]              rsp_blink_total,
   output logic [bec_pkg::INTERVAL_W-1:0]           rsp_mean_interval,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [bec_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [bec_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bec_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);

   logic signed [bec_pkg::SAMPLE_W-1:0]  threshold_ff, threshold_in;
   logic [bec_pkg::TIMEOUT_W-1:0]        timeout_ff, timeout_in;
   bec_pkg::csr_index_type               csr_index;
   logic                                 csr_write;

   logic                                 stage_valid_ff, stage_valid_in;
   logic                                 stage_open_ff, stage_open_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 req_take;
   logic                                 advance;
   bec_pkg::step_type                    step;

   // Register decode and write.
   assign csr_pready = 1'b1;
   assign csr_index  = bec_pkg::csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      timeout_in   = timeout_ff;
      if (csr_write) begin
         unique case (csr_index)
            bec_pkg::REG_THRESHOLD:       threshold_in = csr_pwdata[bec_pkg::SAMPLE_W-1:0];
            bec_pkg::REG_TIMEOUT_SAMPLES: timeout_in   = csr_pwdata[bec_pkg::TIMEOUT_W-1:0];
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (csr_index)
         bec_pkg::REG_THRESHOLD:
            csr_prdata = {{(bec_pkg::CSR_DATA_W - bec_pkg::SAMPLE_W){1'b0}}, threshold_ff};
         bec_pkg::REG_TIMEOUT_SAMPLES:
            csr_prdata = {{(bec_pkg::CSR_DATA_W - bec_pkg::TIMEOUT_W){1'b0}}, timeout_ff};
      endcase
   end

   // The input stage moves on when the result register is empty or being taken,
   // and takes a new transfer whenever it is empty or moving on.
   always_comb begin
      advance        = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall      = stage_valid_ff && !advance;
      req_take       = req_valid && !req_stall;
      stage_valid_in = req_take || (stage_valid_ff && !advance);
      stage_open_in  = req_take ? (req_eye_opening > threshold_ff) : stage_open_ff;
      rsp_valid_in   = advance || (rsp_valid_ff && rsp_stall);
      step.fire      = advance;
      step.now_open  = stage_open_ff;
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= bec_pkg::THRESHOLD_RESET;
         timeout_ff     <= bec_pkg::TIMEOUT_RESET;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         threshold_ff   <= threshold_in;
         timeout_ff     <= timeout_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Open flag of the staged sample.
   always_ff @(posedge clock) begin
      stage_open_ff <= stage_open_in;
   end

   // Blink state and result.
   bec_tracker #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_tracker (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .timeout_samples (timeout_ff),
      .blink_seen      (rsp_blink_seen),
      .blink_total     (rsp_blink_total),
      .mean_interval   (rsp_mean_interval)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bec_tracker.sv
// Blink tracker: closure timing, blink tally and smoothed interval state.
`timescale 1ns / 1ps
`default_nettype none

module bec_tracker #(
   parameter int INDEX_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bec_pkg::step_type                   step,
   input  wire logic [bec_pkg::TIMEOUT_W-1:0]       timeout_samples,
   output logic                                     blink_seen,
   output logic [bec_pkg::TALLY_W-1:0]              blink_total,
   output logic [bec_pkg::INTERVAL_W-1:0]           mean_interval
);

   // The interval sum holds gap/8 plus a 32-bit term, with a carry bit on top.
   localparam int SUM_W = ((INDEX_WIDTH - 3 > 32) ? INDEX_WIDTH - 3 : 32) + 1;

   // Tracker state.
   logic                          was_open_ff, was_open_in;
   logic                          armed_ff, armed_in;
   logic [INDEX_WIDTH-1:0]        index_ff, index_in;
   logic [INDEX_WIDTH-1:0]        closure_len_ff, closure_len_in;
   logic [INDEX_WIDTH-1:0]        midpoint_ff, midpoint_in;
   logic [INDEX_WIDTH-1:0]        last_mid_ff, last_mid_in;
   logic [bec_pkg::INTERVAL_W-1:0] average_ff, average_in;
   logic [bec_pkg::TALLY_W-1:0]   tally_ff, tally_in;
   logic                          seen_ff, seen_in;

   // Decode and arithmetic terms.
   logic                          closing;
   logic                          reopening;
   logic                          in_time;
   logic [INDEX_WIDTH-1:0]        gap;
   logic [34:0]                   times7;
   logic [34:0]                   low_sum;
   logic [SUM_W-1:0]              interval_sum;
   logic [bec_pkg::INTERVAL_W-1:0] average_upd;

   // Edge detection and the closure length check. The closure length and the
   // running midpoint are kept as counters, so no subtraction is needed here.
   always_comb begin
      closing   = was_open_ff && !step.now_open;
      reopening = !was_open_ff && step.now_open && armed_ff;
      in_time   = closure_len_ff <= INDEX_WIDTH'(timeout_samples);
   end

   // Smoothed interval: (7*avg + gap) / 8, computed as gap/8 + (7*avg + gap%8)/8.
   always_comb begin
      gap          = midpoint_ff - last_mid_ff;
      times7       = {average_ff, 3'b000} - {3'b000, average_ff};
      low_sum      = times7 + {32'd0, gap[2:0]};
      interval_sum = SUM_W'(gap[INDEX_WIDTH-1:3]) + SUM_W'(low_sum[34:3]);
      if (interval_sum[SUM_W-1:bec_pkg::INTERVAL_W] != '0) begin
         average_upd = bec_pkg::INTERVAL_MAX;
      end else begin
         average_upd = interval_sum[bec_pkg::INTERVAL_W-1:0];
      end
   end

   // Next state for one sample.
   always_comb begin
      was_open_in    = was_open_ff;
      armed_in       = armed_ff;
      index_in       = index_ff;
      closure_len_in = closure_len_ff;
      midpoint_in    = midpoint_ff;
      last_mid_in    = last_mid_ff;
      average_in     = average_ff;
      tally_in       = tally_ff;
      seen_in        = seen_ff;
      if (step.fire) begin
         was_open_in = step.now_open;
         index_in    = index_ff + INDEX_WIDTH'(1);
         seen_in     = 1'b0;
         // A fresh closure starts its length at one and its midpoint at the
         // current index; otherwise the midpoint moves on every odd length.
         // When the length wraps to zero, the midpoint falls back to the start.
         if (closing) begin
            closure_len_in = INDEX_WIDTH'(1);
            midpoint_in    = index_ff;
         end else if (&closure_len_ff) begin
            closure_len_in = '0;
            midpoint_in    = midpoint_ff - {1'b0, {(INDEX_WIDTH-1){1'b1}}};
         end else begin
            closure_len_in = closure_len_ff + INDEX_WIDTH'(1);
            midpoint_in    = midpoint_ff + INDEX_WIDTH'(closure_len_ff[0]);
         end
         priority if (closing) begin
            armed_in = 1'b1;
         end else if (reopening) begin
            armed_in = 1'b0;
            if (in_time) begin
               if (last_mid_ff != '0) begin
                  average_in = average_upd;
               end
               last_mid_in = midpoint_ff;
               if (tally_ff != bec_pkg::TALLY_MAX) begin
                  tally_in = tally_ff + bec_pkg::TALLY_W'(1);
               end
               seen_in = 1'b1;
            end else begin
               // A closure that ran too long clears the stored midpoint of the last blink.
               last_mid_in = '0;
            end
         end
      end
   end

   // State registers; they also serve as the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         was_open_ff    <= 1'b1;
         armed_ff       <= 1'b0;
         index_ff       <= '0;
         closure_len_ff <= '0;
         midpoint_ff    <= '0;
         last_mid_ff    <= '0;
         average_ff     <= '0;
         tally_ff       <= '0;
         seen_ff        <= 1'b0;
      end else begin
         was_open_ff    <= was_open_in;
         armed_ff       <= armed_in;
         index_ff       <= index_in;
         closure_len_ff <= closure_len_in;
         midpoint_ff    <= midpoint_in;
         last_mid_ff    <= last_mid_in;
         average_ff     <= average_in;
         tally_ff       <= tally_in;
         seen_ff        <= seen_in;
      end
   end

   assign blink_seen    = seen_ff;
   assign blink_total   = tally_ff;
   assign mean_interval = average_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bec_checker.sv
// Port-level checks for the blink event counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bec_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic                           rsp_blink_seen,
   input wire logic [bec_pkg::TALLY_W-1:0]    rsp_blink_total,
   input wire logic [bec_pkg::INTERVAL_W-1:0] rsp_mean_interval
);

   // A stalled result stays valid and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_blink_seen)
         && $stable(rsp_blink_total) && $stable(rsp_mean_interval))
      else $error("stalled result changed");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // With the result register empty, the input side is never held off.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output empty");

   // A sample without a blink leaves tally and interval as the previous result had them.
   a_no_blink_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && !rsp_stall && !reset) && rsp_valid && !rsp_blink_seen
      |-> rsp_blink_total == $past(rsp_blink_total)
         && rsp_mean_interval == $past(rsp_mean_interval))
      else $error("state changed without a blink");

   // A blink adds one to the tally unless it is saturated.
   a_blink_count: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && !rsp_stall && !reset) && rsp_valid && rsp_blink_seen
         && $past(rsp_blink_total) != bec_pkg::TALLY_MAX
      |-> rsp_blink_total == $past(rsp_blink_total) + bec_pkg::TALLY_W'(1))
      else $error("blink tally did not step by one");

endmodule

bind blink_event_counter_core bec_checker u_bec_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_blink_seen    (rsp_blink_seen),
   .rsp_blink_total   (rsp_blink_total),
   .rsp_mean_interval (rsp_mean_interval)
);

`default_nettype wire
